[hw/rtl/tiny_accumulator_cpu_step_core_defines.svh]
// Assertion macros shared by the checker of tiny_accumulator_cpu_step_core.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef TINY_ACCUMULATOR_CPU_STEP_CORE_DEFINES_SVH
`define TINY_ACCUMULATOR_CPU_STEP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TACS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TACS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tacs_pkg.sv]
// Shared types, codes and the microcode table of the tiny accumulator CPU step core.
// No dependencies; the files that use it refer to it by scoped names.
package tacs_pkg;

	localparam int CMD_W    = 2;
	localparam int ADDR_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int ACC_A_W  = 32;
	localparam int PC_OUT_W = 9;
	localparam int ST_W     = 3;
	localparam int PC_RESET = 509;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_SETPC = 2'd2,
		CMD_EXEC  = 2'd3
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_HALTED   = 3'd1,
		ST_BAD_OP   = 3'd2,
		ST_PAST_TOP = 3'd3,
		ST_BAD_ADDR = 3'd4
	} st_t;

	localparam logic [BYTE_W-1:0] OP_STORE_A     = 8'h0C;
	localparam logic [BYTE_W-1:0] OP_LOAD_A      = 8'h37;
	localparam logic [BYTE_W-1:0] OP_LOAD_B      = 8'h38;
	localparam logic [BYTE_W-1:0] OP_INC_A       = 8'h53;
	localparam logic [BYTE_W-1:0] OP_JUMP        = 8'h5A;
	localparam logic [BYTE_W-1:0] OP_BR_A_LT_B   = 8'h5B;
	localparam logic [BYTE_W-1:0] OP_BR_A_GE_IMM = 8'h5D;
	localparam logic [BYTE_W-1:0] OP_HALT        = 8'h64;

	// Microcode step addresses.
	typedef logic [3:0] upc_t;
	localparam upc_t U_IDLE  = 4'd0;
	localparam upc_t U_WR    = 4'd1;
	localparam upc_t U_RD    = 4'd2;
	localparam upc_t U_RDF   = 4'd3;
	localparam upc_t U_SETPC = 4'd4;
	localparam upc_t U_EX0   = 4'd5;
	localparam upc_t U_EX1   = 4'd6;
	localparam upc_t U_OP2   = 4'd7;
	localparam upc_t U_WAIT  = 4'd8;
	localparam upc_t U_EXF   = 4'd9;
	localparam upc_t U_GE2   = 4'd10;
	localparam upc_t U_GE3   = 4'd11;

	// Memory address source.
	typedef enum logic [1:0] {AS_CMD, AS_PC, AS_TGT} asel_t;
	// Register that takes the byte read in this step, once the registered read data arrives.
	typedef enum logic [2:0] {D_NONE, D_OP, D_B1, D_B2, D_B3} dst_t;
	// Result produced when the step completes.
	typedef enum logic [2:0] {F_NONE, F_WR, F_RD, F_SETPC, F_EX} fin_t;
	// Next-step selection.
	typedef enum logic [2:0] {J_SEQ, J_GOTO, J_ACCEPT, J_OP, J_DONE} jmp_t;

	typedef struct packed {
		logic       accept;
		logic       rd_en;
		asel_t      asel;
		logic [1:0] ofs;
		dst_t       dst;
		fin_t       fin;
		jmp_t       jmp;
		upc_t       tgt;
	} ctl_t;

	// Status fed back from the datapath and the request channel.
	typedef struct packed {
		logic              in_fire;
		cmd_t              cmd;
		logic [BYTE_W-1:0] opcode;
		logic              out_free;
	} fb_t;

	function automatic ctl_t ucode(upc_t step);
		ctl_t cw;
		cw = '{accept: 1'b0, rd_en: 1'b0, asel: AS_PC, ofs: 2'd0, dst: D_NONE,
			fin: F_NONE, jmp: J_SEQ, tgt: U_IDLE};
		unique case (step)
			U_IDLE: begin
				cw.accept = 1'b1;
				cw.jmp    = J_ACCEPT;
			end
			U_WR: begin
				cw.asel = AS_CMD;
				cw.fin  = F_WR;
				cw.jmp  = J_DONE;
			end
			U_RD: begin
				cw.rd_en = 1'b1;
				cw.asel  = AS_CMD;
			end
			U_RDF: begin
				cw.asel = AS_CMD;
				cw.fin  = F_RD;
				cw.jmp  = J_DONE;
			end
			U_SETPC: begin
				cw.asel = AS_CMD;
				cw.fin  = F_SETPC;
				cw.jmp  = J_DONE;
			end
			U_EX0: begin
				cw.rd_en = 1'b1;
				cw.ofs   = 2'd0;
				cw.dst   = D_OP;
			end
			U_EX1: begin
				cw.rd_en = 1'b1;
				cw.ofs   = 2'd1;
				cw.dst   = D_B1;
				cw.jmp   = J_OP;
			end
			U_OP2: begin
				cw.rd_en = 1'b1;
				cw.ofs   = 2'd2;
				cw.dst   = D_B2;
				cw.jmp   = J_GOTO;
				cw.tgt   = U_WAIT;
			end
			U_WAIT: begin
				cw.jmp = J_SEQ;
			end
			U_EXF: begin
				cw.asel = AS_TGT;
				cw.fin  = F_EX;
				cw.jmp  = J_DONE;
			end
			U_GE2: begin
				cw.rd_en = 1'b1;
				cw.ofs   = 2'd2;
				cw.dst   = D_B2;
			end
			U_GE3: begin
				cw.rd_en = 1'b1;
				cw.ofs   = 2'd3;
				cw.dst   = D_B3;
				cw.jmp   = J_GOTO;
				cw.tgt   = U_WAIT;
			end
			default: begin
				cw.jmp = J_GOTO;
				cw.tgt = U_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

[hw/rtl/tacs_chan_if.sv]
// Request and result channel interfaces of the tiny accumulator CPU step core.
// Depends on tacs_pkg for field widths.
interface tacs_req_if;
	logic                             valid;
	logic                             ready;
	logic [tacs_pkg::CMD_W-1:0]       command;
	logic [tacs_pkg::ADDR_W-1:0]      address;
	logic [tacs_pkg::BYTE_W-1:0]      write_byte;

	modport source (output valid, command, address, write_byte, input ready);
	modport sink (input valid, command, address, write_byte, output ready);
endinterface

interface tacs_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [tacs_pkg::PC_OUT_W-1:0]    prog_counter;
	logic [tacs_pkg::ACC_A_W-1:0]     reg_a;
	logic [tacs_pkg::BYTE_W-1:0]      reg_b;
	logic [tacs_pkg::BYTE_W-1:0]      read_byte;
	logic [tacs_pkg::ST_W-1:0]        status;

	modport source (output valid, prog_counter, reg_a, reg_b, read_byte, status, input ready);
	modport sink (input valid, prog_counter, reg_a, reg_b, read_byte, status, output ready);
endinterface

[hw/rtl/tacs_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module tacs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/tacs_seq.sv]
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on tacs_pkg for the control word, feedback struct and the ROM.
module tacs_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  tacs_pkg::fb_t   fb,
	output tacs_pkg::ctl_t  cw
);

	tacs_pkg::upc_t upc_q;
	tacs_pkg::upc_t upc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= tacs_pkg::U_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_comb begin
		cw    = tacs_pkg::ucode(upc_q);
		upc_d = upc_q;
		unique case (cw.jmp)
			tacs_pkg::J_SEQ: begin
				upc_d = upc_q + tacs_pkg::upc_t'(1);
			end
			tacs_pkg::J_GOTO: begin
				upc_d = cw.tgt;
			end
			tacs_pkg::J_ACCEPT: begin
				if (fb.in_fire) begin
					unique case (fb.cmd)
						tacs_pkg::CMD_WRITE: upc_d = tacs_pkg::U_WR;
						tacs_pkg::CMD_READ:  upc_d = tacs_pkg::U_RD;
						tacs_pkg::CMD_SETPC: upc_d = tacs_pkg::U_SETPC;
						tacs_pkg::CMD_EXEC:  upc_d = tacs_pkg::U_EX0;
					endcase
				end
			end
			tacs_pkg::J_OP: begin
				// Opcodes with two-byte targets fetch one more operand, the
				// immediate compare fetches two more, the rest fetch no more.
				unique case (fb.opcode) inside
					tacs_pkg::OP_STORE_A, tacs_pkg::OP_JUMP,
					tacs_pkg::OP_BR_A_LT_B: upc_d = tacs_pkg::U_OP2;
					tacs_pkg::OP_BR_A_GE_IMM: upc_d = tacs_pkg::U_GE2;
					default: upc_d = tacs_pkg::U_WAIT;
				endcase
			end
			tacs_pkg::J_DONE: begin
				if (fb.out_free) begin
					upc_d = tacs_pkg::U_IDLE;
				end
			end
			default: begin
				upc_d = tacs_pkg::U_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/tacs_dp.sv]
// Datapath: PC, A, B, operand registers, program memory and result register.
// Depends on tacs_pkg and instantiates tacs_ram.
module tacs_dp #(
	parameter int MEM_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tacs_pkg::ctl_t                cw,
	input  logic                          in_fire,
	input  logic [tacs_pkg::ADDR_W-1:0]   in_address,
	input  logic [tacs_pkg::BYTE_W-1:0]   in_write_byte,
	input  logic                          out_ready,
	output logic                          out_free,
	output logic [tacs_pkg::BYTE_W-1:0]   rd_byte,
	output logic                          out_valid,
	output logic [tacs_pkg::PC_OUT_W-1:0] out_prog_counter,
	output logic [tacs_pkg::ACC_A_W-1:0]  out_reg_a,
	output logic [tacs_pkg::BYTE_W-1:0]   out_reg_b,
	output logic [tacs_pkg::BYTE_W-1:0]   out_read_byte,
	output logic [tacs_pkg::ST_W-1:0]     out_status
);

	localparam int AW  = $clog2(MEM_BYTES);
	localparam int PCW = (AW > tacs_pkg::PC_OUT_W) ? AW : tacs_pkg::PC_OUT_W;
	localparam int NW  = (PCW + 1 > tacs_pkg::ADDR_W) ? PCW + 1 : tacs_pkg::ADDR_W;
	localparam logic [NW-1:0] MEM_END = NW'(MEM_BYTES);

	logic [tacs_pkg::ADDR_W-1:0]  addr_q;
	logic [tacs_pkg::BYTE_W-1:0]  wbyte_q;
	logic [PCW-1:0]               pc_q;
	logic [tacs_pkg::ACC_A_W-1:0] a_q;
	logic [tacs_pkg::BYTE_W-1:0]  b_q;
	logic [tacs_pkg::BYTE_W-1:0]  op_q;
	logic [tacs_pkg::BYTE_W-1:0]  b1_q;
	logic [tacs_pkg::BYTE_W-1:0]  b2_q;
	logic [tacs_pkg::BYTE_W-1:0]  b3_q;
	tacs_pkg::dst_t               lat_q;
	logic                         oob_q;
	logic                         out_valid_q;
	logic [tacs_pkg::PC_OUT_W-1:0] pc_o_q;
	logic [tacs_pkg::ACC_A_W-1:0] a_o_q;
	logic [tacs_pkg::BYTE_W-1:0]  b_o_q;
	logic [tacs_pkg::BYTE_W-1:0]  rb_o_q;
	tacs_pkg::st_t                st_o_q;

	logic [tacs_pkg::ADDR_W-1:0]  tgt;
	logic [NW-1:0]                pc_ext;
	logic [NW-1:0]                maddr;
	logic                         m_ok;
	logic [tacs_pkg::BYTE_W-1:0]  ram_rdata;
	logic [tacs_pkg::BYTE_W-1:0]  wdata;
	logic                         we;
	logic                         fin_go;
	logic [NW-1:0]                npc;
	logic [tacs_pkg::ACC_A_W-1:0] a_ex;
	logic [tacs_pkg::BYTE_W-1:0]  b_ex;
	tacs_pkg::st_t                st_ex;
	logic                         chg;
	logic                         st_wr;
	logic [PCW-1:0]               pc_n;
	logic [tacs_pkg::ACC_A_W-1:0] a_n;
	logic [tacs_pkg::BYTE_W-1:0]  b_n;
	logic [tacs_pkg::BYTE_W-1:0]  rb_n;
	tacs_pkg::st_t                st_n;

	assign tgt    = (op_q == tacs_pkg::OP_BR_A_GE_IMM) ? {b2_q, b3_q} : {b1_q, b2_q};
	assign pc_ext = NW'(pc_q);

	always_comb begin
		case (cw.asel)
			tacs_pkg::AS_CMD: maddr = NW'(addr_q);
			tacs_pkg::AS_PC:  maddr = pc_ext + NW'(cw.ofs);
			tacs_pkg::AS_TGT: maddr = NW'(tgt);
			default:          maddr = pc_ext;
		endcase
	end

	assign m_ok     = maddr < MEM_END;
	assign rd_byte  = oob_q ? '0 : ram_rdata;
	assign out_free = !out_valid_q || out_ready;
	assign fin_go   = (cw.fin != tacs_pkg::F_NONE) && out_free;

	// Instruction effect, from the latched opcode and operands.
	always_comb begin
		npc   = pc_ext;
		a_ex  = a_q;
		b_ex  = b_q;
		st_ex = tacs_pkg::ST_OK;
		chg   = 1'b1;
		st_wr = 1'b0;
		case (op_q)
			tacs_pkg::OP_STORE_A: begin
				npc   = pc_ext + NW'(3);
				st_wr = 1'b1;
			end
			tacs_pkg::OP_LOAD_A: begin
				npc  = pc_ext + NW'(2);
				a_ex = tacs_pkg::ACC_A_W'(b1_q);
			end
			tacs_pkg::OP_LOAD_B: begin
				npc  = pc_ext + NW'(2);
				b_ex = b1_q;
			end
			tacs_pkg::OP_INC_A: begin
				npc  = pc_ext + NW'(1);
				a_ex = a_q + tacs_pkg::ACC_A_W'(1);
			end
			tacs_pkg::OP_JUMP: begin
				npc = NW'(tgt);
			end
			tacs_pkg::OP_BR_A_LT_B: begin
				npc = (a_q < tacs_pkg::ACC_A_W'(b_q)) ? NW'(tgt) : pc_ext + NW'(3);
			end
			tacs_pkg::OP_BR_A_GE_IMM: begin
				npc = (a_q >= tacs_pkg::ACC_A_W'(b1_q)) ? NW'(tgt) : pc_ext + NW'(4);
			end
			tacs_pkg::OP_HALT: begin
				st_ex = tacs_pkg::ST_HALTED;
				chg   = 1'b0;
			end
			default: begin
				st_ex = tacs_pkg::ST_BAD_OP;
				chg   = 1'b0;
			end
		endcase
		// Next PC past the top: drop every change.
		if (chg && npc >= MEM_END) begin
			st_ex = tacs_pkg::ST_PAST_TOP;
			chg   = 1'b0;
		end
	end

	// Result of the finishing step.
	always_comb begin
		pc_n = pc_q;
		a_n  = a_q;
		b_n  = b_q;
		rb_n = '0;
		st_n = tacs_pkg::ST_OK;
		we   = 1'b0;
		case (cw.fin)
			tacs_pkg::F_WR: begin
				if (m_ok) begin
					we = fin_go;
				end else begin
					st_n = tacs_pkg::ST_BAD_ADDR;
				end
			end
			tacs_pkg::F_RD: begin
				if (m_ok) begin
					rb_n = rd_byte;
				end else begin
					st_n = tacs_pkg::ST_BAD_ADDR;
				end
			end
			tacs_pkg::F_SETPC: begin
				if (m_ok) begin
					pc_n = PCW'(addr_q);
				end else begin
					st_n = tacs_pkg::ST_BAD_ADDR;
				end
			end
			tacs_pkg::F_EX: begin
				st_n = st_ex;
				if (chg) begin
					pc_n = npc[PCW-1:0];
					a_n  = a_ex;
					b_n  = b_ex;
					// Store to a target beyond memory is dropped.
					we   = fin_go && st_wr && m_ok;
				end
			end
			default: ;
		endcase
	end

	assign wdata = (cw.fin == tacs_pkg::F_WR) ? wbyte_q : a_q[tacs_pkg::BYTE_W-1:0];

	tacs_ram #(
		.WIDTH (tacs_pkg::BYTE_W),
		.DEPTH (MEM_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.re    (cw.rd_en),
		.addr  (maddr[AW-1:0]),
		.wdata (wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PCW'(tacs_pkg::PC_RESET);
			a_q         <= '0;
			b_q         <= '0;
			lat_q       <= tacs_pkg::D_NONE;
			oob_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			lat_q <= cw.rd_en ? cw.dst : tacs_pkg::D_NONE;
			if (cw.rd_en) begin
				oob_q <= !m_ok;
			end
			if (fin_go) begin
				pc_q        <= pc_n;
				a_q         <= a_n;
				b_q         <= b_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_q  <= in_address;
			wbyte_q <= in_write_byte;
		end
		case (lat_q)
			tacs_pkg::D_OP: op_q <= rd_byte;
			tacs_pkg::D_B1: b1_q <= rd_byte;
			tacs_pkg::D_B2: b2_q <= rd_byte;
			tacs_pkg::D_B3: b3_q <= rd_byte;
			default: ;
		endcase
		if (fin_go) begin
			pc_o_q <= pc_n[tacs_pkg::PC_OUT_W-1:0];
			a_o_q  <= a_n;
			b_o_q  <= b_n;
			rb_o_q <= rb_n;
			st_o_q <= st_n;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_prog_counter = pc_o_q;
	assign out_reg_a        = a_o_q;
	assign out_reg_b        = b_o_q;
	assign out_read_byte    = rb_o_q;
	assign out_status       = st_o_q;

endmodule

[hw/rtl/tiny_accumulator_cpu_step_core.sv]
// Top level of the tiny accumulator CPU step core: sequencer plus datapath.
// Depends on tacs_pkg, tacs_chan_if, tacs_seq, tacs_dp and tacs_ram.
//
//   channel  dir  beat carries
//   -------  ---  ---------------------------------------------------------
//   req      in   command, address, write_byte
//   rsp      out  prog_counter, reg_a, reg_b, read_byte, status
//
// One command at a time, taken in the idle step. A write or set-PC then
// finishes in its one step (WR, SETPC), a read in RD then RDF; execute runs
// EX0 and EX1, then OP2 (store, jump, branch A<B), GE2 and GE3 (branch
// A>=imm) or no fetch (load, increment, halt, invalid opcode), then WAIT and
// EXF. The result beat is registered in the finishing step, which stalls while
// the result slot is full. The single memory port reads at most a byte a step.
// Reset (arst_n low) sets PC to 509, clears A and B; memory is not cleared.
// A waiting result beat does not block the next command: it is held in the
// result register, and only the finishing step of the next command stalls.
module tiny_accumulator_cpu_step_core #(
	parameter int MEM_BYTES = 512
) (
	input logic         clk,
	input logic         arst_n,
	tacs_req_if.sink    req,
	tacs_rsp_if.source  rsp
);

	tacs_pkg::ctl_t                cw;
	tacs_pkg::fb_t                 fb;
	logic                          in_fire;
	logic                          out_free;
	logic [tacs_pkg::BYTE_W-1:0]   rd_byte;

	// Accept a request beat only in the idle microstep.
	assign req.ready = cw.accept;
	assign in_fire   = req.valid && cw.accept;

	// Feed back what the jump logic needs: the command on acceptance, the
	// fetched opcode for decode dispatch and whether the result slot is free.
	assign fb.in_fire  = in_fire;
	assign fb.cmd      = tacs_pkg::cmd_t'(req.command);
	assign fb.opcode   = rd_byte;
	assign fb.out_free = out_free;

	tacs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fb     (fb),
		.cw     (cw)
	);

	tacs_dp #(
		.MEM_BYTES (MEM_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cw               (cw),
		.in_fire          (in_fire),
		.in_address       (req.address),
		.in_write_byte    (req.write_byte),
		.out_ready        (rsp.ready),
		.out_free         (out_free),
		.rd_byte          (rd_byte),
		.out_valid        (rsp.valid),
		.out_prog_counter (rsp.prog_counter),
		.out_reg_a        (rsp.reg_a),
		.out_reg_b        (rsp.reg_b),
		.out_read_byte    (rsp.read_byte),
		.out_status       (rsp.status)
	);

endmodule

[hw/rtl/tacs_chk.sv]
// Port-level checker of tiny_accumulator_cpu_step_core, bound to the top level.
// Depends on tacs_pkg and the assertion macros of the defines header.
`include "tiny_accumulator_cpu_step_core_defines.svh"

module tacs_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [tacs_pkg::PC_OUT_W-1:0] rsp_prog_counter,
	input logic [tacs_pkg::ACC_A_W-1:0]  rsp_reg_a,
	input logic [tacs_pkg::BYTE_W-1:0]   rsp_read_byte,
	input logic [tacs_pkg::ST_W-1:0]     rsp_status
);

	logic       req_acc;
	logic       rsp_acc;
	logic [1:0] cnt_q;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Commands accepted whose result beat is not yet taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(req_acc) - 2'(rsp_acc);
		end
	end

	`TACS_ASSERT(a_no_orphan, rsp_acc, cnt_q != 2'd0, "result beat without a pending command")
	`TACS_ASSERT(a_one_ahead, req_acc, cnt_q <= 2'd1, "command taken with two results pending")
	`TACS_ASSERT(a_status_code, rsp_valid, rsp_status <= tacs_pkg::ST_BAD_ADDR, "bad status code")
	`TACS_ASSERT(a_read_zero, rsp_valid && rsp_status != tacs_pkg::ST_OK, rsp_read_byte == 8'd0, "read byte set on failed command")
	`TACS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_reg_a) && $stable(rsp_prog_counter), "stalled result beat changed")

endmodule

bind tiny_accumulator_cpu_step_core tacs_chk u_tacs_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_prog_counter (rsp.prog_counter),
	.rsp_reg_a        (rsp.reg_a),
	.rsp_read_byte    (rsp.read_byte),
	.rsp_status       (rsp.status)
);

[tb/tb.sv]
// Self-checking testbench for tiny_accumulator_cpu_step_core: directed corner cases, then
// random programs loaded, pointed to and stepped, each result beat checked against a predictor.
// Depends on tacs_pkg, tacs_chan_if and the core itself.
module tb;

	localparam int MEM_BYTES  = 512;
	localparam int ITEM_GOAL  = 450;
	localparam int QUIET_MAX  = 3000;
	localparam int HOLD_LEN   = 150;
	localparam int SETTLE_CYC = 20;

	// One result beat as the core should present it.
	typedef struct {
		logic [tacs_pkg::PC_OUT_W-1:0] pc;
		logic [tacs_pkg::ACC_A_W-1:0]  a;
		logic [tacs_pkg::BYTE_W-1:0]   b;
		logic [tacs_pkg::BYTE_W-1:0]   rbyte;
		tacs_pkg::st_t                 st;
	} cpu_view_t;

	// Shadow CPU plus the queue of results it has worked out but not yet seen.
	class cpu_scoreboard;
		logic [tacs_pkg::BYTE_W-1:0]  mem_img[MEM_BYTES];
		bit                           written[MEM_BYTES];
		int unsigned                  pc_q;
		logic [tacs_pkg::ACC_A_W-1:0] acc_a;
		logic [tacs_pkg::BYTE_W-1:0]  acc_b;
		cpu_view_t                    expected_q[$];
		int                           err_cnt;
		int                           checked;
		int                           cmd_seen[4];
		int                           st_seen[5];

		function new();
			pc_q  = tacs_pkg::PC_RESET;
			acc_a = '0;
			acc_b = '0;
			foreach (written[i]) written[i] = 1'b0;
		endfunction

		function logic [tacs_pkg::BYTE_W-1:0] fetch(int unsigned adr);
			return (adr < MEM_BYTES) ? mem_img[adr] : 8'h00;
		endfunction

		function int unsigned word_at(int unsigned adr);
			return {16'h0000, fetch(adr), fetch(adr + 1)};
		endfunction

		// Execute the instruction at the PC; state changes only on a legal next PC.
		function tacs_pkg::st_t step_exec();
			int unsigned                 at;
			int unsigned                 nxt;
			int unsigned                 tgt;
			logic [tacs_pkg::BYTE_W-1:0] op;
			at = pc_q;
			op = fetch(at);
			case (op)
				tacs_pkg::OP_STORE_A: begin
					tgt = word_at(at + 1);
					nxt = at + 3;
					if (nxt >= MEM_BYTES) return tacs_pkg::ST_PAST_TOP;
					if (tgt < MEM_BYTES) begin
						mem_img[tgt] = acc_a[7:0];
						written[tgt] = 1'b1;
					end
					pc_q = nxt;
					return tacs_pkg::ST_OK;
				end
				tacs_pkg::OP_LOAD_A, tacs_pkg::OP_LOAD_B: begin
					nxt = at + 2;
					if (nxt >= MEM_BYTES) return tacs_pkg::ST_PAST_TOP;
					if (op == tacs_pkg::OP_LOAD_A) acc_a = {24'h0, fetch(at + 1)};
					else acc_b = fetch(at + 1);
					pc_q = nxt;
					return tacs_pkg::ST_OK;
				end
				tacs_pkg::OP_INC_A: begin
					nxt = at + 1;
					if (nxt >= MEM_BYTES) return tacs_pkg::ST_PAST_TOP;
					acc_a = acc_a + 1;
					pc_q  = nxt;
					return tacs_pkg::ST_OK;
				end
				tacs_pkg::OP_JUMP: nxt = word_at(at + 1);
				tacs_pkg::OP_BR_A_LT_B:
					nxt = (acc_a < {24'h0, acc_b}) ? word_at(at + 1) : at + 3;
				tacs_pkg::OP_BR_A_GE_IMM:
					nxt = (acc_a >= {24'h0, fetch(at + 1)}) ? word_at(at + 2) : at + 4;
				tacs_pkg::OP_HALT: return tacs_pkg::ST_HALTED;
				default:           return tacs_pkg::ST_BAD_OP;
			endcase
			if (nxt >= MEM_BYTES) return tacs_pkg::ST_PAST_TOP;
			pc_q = nxt;
			return tacs_pkg::ST_OK;
		endfunction

		function void note_command(tacs_pkg::cmd_t c, logic [tacs_pkg::ADDR_W-1:0] adr,
				logic [tacs_pkg::BYTE_W-1:0] wb);
			cpu_view_t v;
			v.rbyte = '0;
			v.st    = tacs_pkg::ST_OK;
			case (c)
				tacs_pkg::CMD_WRITE: begin
					if (adr >= MEM_BYTES) v.st = tacs_pkg::ST_BAD_ADDR;
					else begin
						mem_img[adr] = wb;
						written[adr] = 1'b1;
					end
				end
				tacs_pkg::CMD_READ: begin
					if (adr >= MEM_BYTES) v.st = tacs_pkg::ST_BAD_ADDR;
					else v.rbyte = mem_img[adr];
				end
				tacs_pkg::CMD_SETPC: begin
					if (adr >= MEM_BYTES) v.st = tacs_pkg::ST_BAD_ADDR;
					else pc_q = adr;
				end
				default: v.st = step_exec();
			endcase
			v.pc  = pc_q[tacs_pkg::PC_OUT_W-1:0];
			v.a   = acc_a;
			v.b   = acc_b;
			expected_q.push_back(v);
			cmd_seen[c]++;
		endfunction

		function void cmp_field(string fld, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s: expected 0x%0h, got 0x%0h", fld, exp_v, act_v);
				err_cnt++;
			end
		endfunction

		function void check_result(logic [tacs_pkg::PC_OUT_W-1:0] pc,
				logic [tacs_pkg::ACC_A_W-1:0] a, logic [tacs_pkg::BYTE_W-1:0] b,
				logic [tacs_pkg::BYTE_W-1:0] rbyte, logic [tacs_pkg::ST_W-1:0] st);
			cpu_view_t e;
			if (expected_q.size() == 0) begin
				$error("result beat with no command outstanding");
				err_cnt++;
				return;
			end
			e = expected_q.pop_front();
			cmp_field("prog_counter", e.pc, pc);
			cmp_field("reg_a", e.a, a);
			cmp_field("reg_b", e.b, b);
			cmp_field("read_byte", e.rbyte, rbyte);
			cmp_field("status", e.st, st);
			st_seen[e.st]++;
			checked++;
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tacs_req_if req_ch ();
	tacs_rsp_if rsp_ch ();

	tiny_accumulator_cpu_step_core #(
		.MEM_BYTES(MEM_BYTES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	cpu_scoreboard sb = new();

	int tx_idle_pct;
	int rx_idle_pct;
	int sent;
	int quiet_cyc;
	int hold_cnt;
	bit hold_req;

	// Clock and the single reset pulse.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Park every core input at a known value from time zero.
	initial begin
		req_ch.valid      <= 1'b0;
		req_ch.command    <= tacs_pkg::CMD_WRITE;
		req_ch.address    <= '0;
		req_ch.write_byte <= '0;
		rsp_ch.ready      <= 1'b0;
		hold_req          <= 1'b0;
		hold_cnt           = 0;
	end

	// Result side: check each accepted beat, then choose ready for the next cycle.
	// A long hold-off is counted here so the core backs up and stalls its input.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.prog_counter, rsp_ch.reg_a, rsp_ch.reg_b,
					rsp_ch.read_byte, rsp_ch.status);
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req     <= 1'b0;
				hold_cnt      = HOLD_LEN;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Watchdog: end the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cyc <= 0;
		end else if (quiet_cyc >= QUIET_MAX) begin
			$display("watchdog: no beat for %0d cycles", quiet_cyc);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cyc <= quiet_cyc + 1;
		end
	end

	// Offer one command beat, idling first at random; note it in the shadow CPU
	// at the edge that accepts it. Valid stays high so back-to-back beats need no gap.
	task automatic send_cmd(tacs_pkg::cmd_t c, logic [tacs_pkg::ADDR_W-1:0] adr,
			logic [tacs_pkg::BYTE_W-1:0] wb);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.command    <= c;
		req_ch.address    <= adr;
		req_ch.write_byte <= wb;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_command(c, adr, wb);
		sent++;
	endtask

	function automatic logic [tacs_pkg::BYTE_W-1:0] rand_opcode();
		logic [tacs_pkg::BYTE_W-1:0] ops[8];
		ops = '{tacs_pkg::OP_STORE_A, tacs_pkg::OP_LOAD_A, tacs_pkg::OP_LOAD_B,
			tacs_pkg::OP_INC_A, tacs_pkg::OP_JUMP, tacs_pkg::OP_BR_A_LT_B,
			tacs_pkg::OP_BR_A_GE_IMM, tacs_pkg::OP_HALT};
		if ($urandom_range(0, 99) < 85) return ops[$urandom_range(0, 7)];
		return 8'($urandom);
	endfunction

	// Branch target: often near the program, often anywhere, sometimes past the top.
	function automatic logic [tacs_pkg::ADDR_W-1:0] rand_target(int unsigned base);
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 16'((base + $urandom_range(0, 15)) % MEM_BYTES);
		if (r < 85) return 16'($urandom_range(0, MEM_BYTES - 1));
		return 16'($urandom);
	endfunction

	function automatic void add_instr(ref logic [tacs_pkg::BYTE_W-1:0] code[$],
			input int unsigned base);
		logic [tacs_pkg::BYTE_W-1:0] op;
		logic [tacs_pkg::ADDR_W-1:0] tgt;
		op  = rand_opcode();
		tgt = rand_target(base);
		code.push_back(op);
		case (op)
			tacs_pkg::OP_STORE_A, tacs_pkg::OP_JUMP, tacs_pkg::OP_BR_A_LT_B: begin
				code.push_back(tgt[15:8]);
				code.push_back(tgt[7:0]);
			end
			tacs_pkg::OP_LOAD_A, tacs_pkg::OP_LOAD_B:
				code.push_back(8'($urandom));
			tacs_pkg::OP_BR_A_GE_IMM: begin
				// Half the time pick an immediate from 0 to 8, biasing it low so the branch is taken more often.
				code.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 8)) :
					8'($urandom));
				code.push_back(tgt[15:8]);
				code.push_back(tgt[7:0]);
			end
			default: ;
		endcase
	endfunction

	// Fill any unwritten byte the core may fetch at the PC, then step once.
	task automatic exec_one();
		int unsigned at;
		at = sb.pc_q;
		for (int i = 0; i < 4; i++)
			if (at + i < MEM_BYTES && !sb.written[at + i])
				send_cmd(tacs_pkg::CMD_WRITE, 16'(at + i),
					(i == 0) ? rand_opcode() : 8'($urandom));
		send_cmd(tacs_pkg::CMD_EXEC, 16'($urandom), 8'($urandom));
	endtask

	// Stray command of any kind; reads only touch written bytes or bad addresses.
	task automatic noise_cmd();
		logic [tacs_pkg::ADDR_W-1:0] adr;
		bit                          hit;
		hit = 1'b0;
		case ($urandom_range(0, 3))
			0: begin
				adr = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, MEM_BYTES - 1)) :
					16'($urandom);
				send_cmd(tacs_pkg::CMD_WRITE, adr, 8'($urandom));
			end
			1: begin
				repeat (8) begin
					if (!hit) begin
						adr = 16'($urandom_range(0, MEM_BYTES - 1));
						hit = sb.written[adr];
					end
				end
				if (!hit || $urandom_range(0, 99) < 20)
					adr = 16'($urandom_range(MEM_BYTES, 65535));
				send_cmd(tacs_pkg::CMD_READ, adr, 8'($urandom));
			end
			2: begin
				adr = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, MEM_BYTES - 1)) :
					16'($urandom);
				send_cmd(tacs_pkg::CMD_SETPC, adr, 8'($urandom));
			end
			default: exec_one();
		endcase
	endtask

	// Load a few instructions, point the PC at them and step through.
	task automatic run_program();
		int unsigned                 base;
		logic [tacs_pkg::BYTE_W-1:0] code[$];
		int                          k;
		base = ($urandom_range(0, 99) < 70) ? $urandom_range(0, MEM_BYTES - 20) :
			$urandom_range(MEM_BYTES - 12, MEM_BYTES - 1);
		k = $urandom_range(1, 6);
		repeat (k) add_instr(code, base);
		foreach (code[i]) begin
			if (base + i < MEM_BYTES) begin
				if ($urandom_range(0, 99) < 8) noise_cmd();
				send_cmd(tacs_pkg::CMD_WRITE, 16'(base + i), code[i]);
			end
		end
		send_cmd(tacs_pkg::CMD_SETPC, 16'(base), 8'($urandom));
		repeat ($urandom_range(1, k + 3)) exec_one();
	endtask

	initial begin
		int ph_stop;
		sent        = 0;
		tx_idle_pct = 35;
		rx_idle_pct = 66;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed: a store at the reset PC 509 would run past the top.
		send_cmd(tacs_pkg::CMD_WRITE, 16'd509, tacs_pkg::OP_STORE_A);
		send_cmd(tacs_pkg::CMD_WRITE, 16'd510, 8'h01);
		send_cmd(tacs_pkg::CMD_WRITE, 16'd511, 8'hFF);
		exec_one();
		// Jump at 509 to 0x01FF, then a branch on A >= imm whose operands lie
		// beyond memory and read as zero, so it is taken to address 0.
		send_cmd(tacs_pkg::CMD_WRITE, 16'd509, tacs_pkg::OP_JUMP);
		exec_one();
		send_cmd(tacs_pkg::CMD_WRITE, 16'd511, tacs_pkg::OP_BR_A_GE_IMM);
		exec_one();
		// Store to 0xFFFF is dropped but the PC advances; then halt twice.
		send_cmd(tacs_pkg::CMD_WRITE, 16'd0, tacs_pkg::OP_STORE_A);
		send_cmd(tacs_pkg::CMD_WRITE, 16'd1, 8'hFF);
		send_cmd(tacs_pkg::CMD_WRITE, 16'd2, 8'hFF);
		send_cmd(tacs_pkg::CMD_WRITE, 16'd3, tacs_pkg::OP_HALT);
		send_cmd(tacs_pkg::CMD_WRITE, 16'd4, 8'h00);
		send_cmd(tacs_pkg::CMD_WRITE, 16'd5, 8'h00);
		send_cmd(tacs_pkg::CMD_WRITE, 16'd6, 8'h00);
		repeat (3) exec_one();
		// Bad addresses on write, read and set-PC; a good read at the top.
		send_cmd(tacs_pkg::CMD_WRITE, 16'hFFFF, 8'hFF);
		send_cmd(tacs_pkg::CMD_READ, 16'h0200, 8'h00);
		send_cmd(tacs_pkg::CMD_SETPC, 16'hFFFF, 8'h00);
		send_cmd(tacs_pkg::CMD_READ, 16'd511, 8'h00);
		// 0x01 at 510 is no opcode.
		send_cmd(tacs_pkg::CMD_SETPC, 16'd510, 8'h00);
		exec_one();

		// Random programs in three idle patterns; the last one also holds the result side off.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 35; rx_idle_pct = 66; end
				1: begin tx_idle_pct = 66; rx_idle_pct = 35; end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					hold_req   <= 1'b1;
				end
			endcase
			ph_stop = (ph + 1) * ITEM_GOAL / 3;
			while (sent < ph_stop) begin
				if ($urandom_range(0, 99) < 15) noise_cmd();
				else run_program();
			end
		end
		req_ch.valid <= 1'b0;

		// Drain the outstanding results, then let the core settle.
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		$display("Covered %0d commands: %0d writes, %0d reads, %0d PC loads, %0d steps.",
			sent, sb.cmd_seen[tacs_pkg::CMD_WRITE], sb.cmd_seen[tacs_pkg::CMD_READ],
			sb.cmd_seen[tacs_pkg::CMD_SETPC], sb.cmd_seen[tacs_pkg::CMD_EXEC]);
		$display("Checked %0d results: ok %0d, halt %0d, bad op %0d, past top %0d, bad addr %0d.",
			sb.checked, sb.st_seen[tacs_pkg::ST_OK], sb.st_seen[tacs_pkg::ST_HALTED],
			sb.st_seen[tacs_pkg::ST_BAD_OP], sb.st_seen[tacs_pkg::ST_PAST_TOP],
			sb.st_seen[tacs_pkg::ST_BAD_ADDR]);
		if (sb.err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
